// ===== rtl/core/ouvs_pkg.sv =====
// Package for the ordered unique value set: operation and status codes,
// field widths and the control group that the top level sends to each cell.
// No dependencies.
`default_nettype none

package ouvs_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;

    // Operation codes (code 3 behaves as a search)
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

    // Update strobes broadcast to the row of cells
    typedef struct packed {
        logic ins;  // append the request value at the tail cell
        logic del;  // remove the matching cell, later cells move up
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/ouvs_req_if.sv =====
// Request channel of the ordered unique value set: valid/ready plus
// operation and value. Depends on ouvs_pkg.
`default_nettype none

interface ouvs_req_if
    import ouvs_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ouvs_rsp_if.sv =====
// Response channel of the ordered unique value set: valid/ready plus
// found, position and status. Depends on ouvs_pkg.
`default_nettype none

interface ouvs_rsp_if
    import ouvs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output found, output position, output status,
                    input ready);
    modport sink   (input valid, input found, input position, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ouvs_cell.sv =====
// One storage cell of the set: holds a value and its valid flag, compares
// against the request and shifts from its right neighbor on delete.
// Depends on ouvs_pkg.
`default_nettype none

module ouvs_cell
    import ouvs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // compare strobe and request value, at item accept
    input  wire logic             i_cmp_en,
    input  wire logic [VAL_W-1:0] i_cmp_value,
    // update strobes and value to append
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [VAL_W-1:0] i_ins_value,
    // left neighbor
    input  wire logic             i_left_valid,
    input  wire logic             i_left_seen,
    // right neighbor
    input  wire logic [VAL_W-1:0] i_right_value,
    input  wire logic             i_right_valid,
    // to neighbors and top
    output logic [VAL_W-1:0]      o_value,
    output logic                  o_valid,
    output logic                  o_seen,
    output logic                  o_match
);

    logic [VAL_W-1:0] r_value;
    logic             r_valid;
    logic             r_match;
    logic             n_shift;
    logic             n_append;

    // match at or left of this cell: this cell takes its right neighbor
    assign o_seen   = i_left_seen | r_match;
    assign n_shift  = i_ctl.del & o_seen;
    // tail cell is the first empty one
    assign n_append = i_ctl.ins & i_left_valid & ~r_valid;

    // compare registered at accept; the set holds still until the update
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_match <= r_valid & (r_value == i_cmp_value);
        end
    end

    // stored value
    always_ff @(posedge i_clk) begin
        if (n_shift) begin
            r_value <= i_right_value;
        end else if (n_append) begin
            r_value <= i_ins_value;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_shift) begin
            r_valid <= i_right_valid;
        end else if (n_append) begin
            r_valid <= 1'b1;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_unique_value_set_unit.sv =====
// Ordered unique value set: a row of CAPACITY cells holding distinct signed
// 32-bit values in insertion order, with search, insert and delete.
//
// Channels: i_req carries operation and value, o_rsp carries found,
// position and status; both move an item when valid and ready are high.
// Each request gives exactly one response.
// On accept every cell registers its compare; in the update step that
// follows, once the response register is free, the match is decoded,
// the row updated and the response register loaded. i_req.ready is low
// while an item is in flight, so a new item is taken only after the
// compare and update steps over the cell row of the last one are done.
// A delete shifts every cell right of the match one place left in the same
// update cycle; an insert writes the first empty cell.
// Reset (i_rst_n low, synchronous) empties the set and drops any pending
// item and response; stored values need no clearing.
// A stalled receiver holds the response register; one more request is
// accepted meanwhile and waits in its update cycle until the register frees.
// Depends on ouvs_pkg, ouvs_req_if, ouvs_rsp_if and ouvs_cell.
`default_nettype none

module ordered_unique_value_set_unit
    import ouvs_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ouvs_req_if.sink   i_req,
    ouvs_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (IDX_W < POS_W) ? IDX_W : POS_W;

    logic                r_busy;
    logic [OP_W-1:0]     r_op;
    logic [VAL_W-1:0]    r_val;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;
    logic                r_found;
    logic [POS_W-1:0]    r_pos;
    logic [STATUS_W-1:0] r_status;

    logic                n_accept;
    logic                n_exec;
    logic                n_hit;
    logic [IDX_W-1:0]    n_hit_idx;
    logic                n_empty;
    logic                n_full;
    logic                n_found;
    logic [POS_W-1:0]    n_pos;
    logic [STATUS_W-1:0] n_status;
    t_cell_ctl           n_ctl;

    logic [VAL_W-1:0]    w_value [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_seen;
    logic [CAPACITY-1:0] w_match;

    // handshake
    assign i_req.ready = ~r_busy;
    assign n_accept    = i_req.valid & ~r_busy;
    assign n_exec      = r_busy & ~(r_out_valid & ~o_rsp.ready);

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ouvs_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmp_en      (n_accept),
            .i_cmp_value   (i_req.value),
            .i_ctl         (n_ctl),
            .i_ins_value   (r_val),
            .i_left_valid  ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g - 1]),
            .i_left_seen   ((g == 0) ? 1'b0 : w_seen[(g == 0) ? 0 : g - 1]),
            .i_right_value (w_value[(g == CAPACITY - 1) ? g : g + 1]),
            .i_right_valid ((g == CAPACITY - 1) ? 1'b0
                                                : w_valid[(g == CAPACITY - 1) ? g : g + 1]),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_seen        (w_seen[g]),
            .o_match       (w_match[g])
        );
    end

    // match index: values are distinct, so at most one cell matches
    always_comb begin
        n_hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                n_hit_idx = n_hit_idx | IDX_W'(i);
            end
        end
    end

    assign n_hit   = |w_match;
    assign n_empty = (r_count == '0);
    assign n_full  = (r_count == CNT_W'(CAPACITY));

    // result and update decode
    always_comb begin
        n_found    = 1'b0;
        n_pos      = '0;
        n_status   = ST_MISS;
        n_ctl.ins  = 1'b0;
        n_ctl.del  = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (n_hit) begin
                    n_found  = 1'b1;
                    n_pos    = POS_W'(n_hit_idx[PW-1:0]);
                    n_status = ST_DUP;
                end else if (n_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_pos     = POS_W'(r_count[PW-1:0]);
                    n_status  = ST_OK;
                    n_ctl.ins = n_exec;
                end
            end
            OP_DELETE: begin
                if (n_empty) begin
                    n_status = ST_EMPTY;
                end else if (n_hit) begin
                    n_found   = 1'b1;
                    n_pos     = POS_W'(n_hit_idx[PW-1:0]);
                    n_status  = ST_OK;
                    n_ctl.del = n_exec;
                end
            end
            default: begin
                if (n_empty) begin
                    n_status = ST_EMPTY;
                end else if (n_hit) begin
                    n_found  = 1'b1;
                    n_pos    = POS_W'(n_hit_idx[PW-1:0]);
                    n_status = ST_OK;
                end
            end
        endcase
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_op  <= i_req.operation;
            r_val <= i_req.value;
        end
    end

    // control: busy flag, entry count, response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_accept) begin
                r_busy <= 1'b1;
            end else if (n_exec) begin
                r_busy <= 1'b0;
            end
            if (n_ctl.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (n_ctl.del) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (n_exec) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (n_exec) begin
            r_found  <= n_found;
            r_pos    <= n_pos;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_found;
    assign o_rsp.position = r_pos;
    assign o_rsp.status   = r_status;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ordered_unique_value_set_unit: directed and random
// search/insert/delete items checked against a queue-based shadow of the set.
// Depends on ouvs_pkg, ouvs_req_if, ouvs_rsp_if and the unit itself.

module tb_top;
    import ouvs_pkg::*;

    localparam int SET_CAPACITY = 32;
    localparam int MAX_GAP      = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 560;
    localparam int POOL_SIZE    = 40;

    // Code 3 is not used by the block and falls back to a search
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
    } t_set_reply;

    logic i_clk;
    logic i_rst_n;

    ouvs_req_if req_if ();
    ouvs_rsp_if rsp_if ();

    ordered_unique_value_set_unit #(
        .CAPACITY(SET_CAPACITY)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the set, oldest entry at index 0
    logic signed [VAL_W-1:0] shadow_set[$];
    t_set_reply              expected_replies[$];
    logic signed [VAL_W-1:0] value_pool[POOL_SIZE];

    int err_count     = 0;
    int replies_seen  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit rsp_hold      = 1'b0;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Apply one request to the shadow set and return the reply it earns
    function automatic t_set_reply apply_to_set(input logic [OP_W-1:0] op,
                                                input logic signed [VAL_W-1:0] val);
        t_set_reply r;
        int         hit_idx;
        r       = '{found: 1'b0, position: '0, status: ST_OK};
        hit_idx = -1;
        foreach (shadow_set[i])
            if (hit_idx < 0 && shadow_set[i] == val) hit_idx = i;
        case (op)
            OP_INSERT: begin
                if (hit_idx >= 0) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(hit_idx);
                    r.status   = ST_DUP;
                end else if (shadow_set.size() >= SET_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    r.position = POS_W'(shadow_set.size());
                    shadow_set.push_back(val);
                end
            end
            OP_DELETE: begin
                if (shadow_set.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit_idx < 0) begin
                    r.status = ST_MISS;
                end else begin
                    shadow_set.delete(hit_idx);
                    r.found    = 1'b1;
                    r.position = POS_W'(hit_idx);
                end
            end
            default: begin
                // search, and the spare code acting as one
                if (shadow_set.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit_idx >= 0) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(hit_idx);
                end else begin
                    r.status = ST_MISS;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH reply %0d %s: got %0d, want %0d", replies_seen, what, got, want);
        err_count++;
    endtask

    // Offer one item after a random gap, predict its reply on acceptance
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        for (int k = 0; k < gap; k++) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= val;
        do @(posedge i_clk); while (!req_if.ready);
        expected_replies.push_back(apply_to_set(op, val));
    endtask

    // Receiver: random ready, forced low while a hold-off is active
    always @(negedge i_clk) begin
        rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Reply checker
    always @(posedge i_clk) begin
        t_set_reply want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                report_mismatch("with nothing outstanding", 1, 0);
            end else begin
                want = expected_replies.pop_front();
                if (rsp_if.found !== want.found)
                    report_mismatch("found", rsp_if.found, want.found);
                if (rsp_if.position !== want.position)
                    report_mismatch("position", rsp_if.position, want.position);
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 70) return value_pool[$urandom_range(POOL_SIZE-1)];
        if (r < 85 && shadow_set.size() != 0)
            return shadow_set[$urandom_range(shadow_set.size()-1)];
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int ins_weight);
        int r;
        r = $urandom_range(99);
        if (r < ins_weight) return OP_INSERT;
        if (r < ins_weight + (100 - ins_weight) * 3 / 5) return OP_DELETE;
        if (r < 95) return OP_SEARCH;
        return OP_SPARE;
    endfunction

    // Requests against an empty set
    task automatic test_empty_requests();
        send_item(OP_SEARCH, 32'sd5);
        send_item(OP_DELETE, VAL_MIN);
        send_item(OP_SPARE, VAL_MAX);
    endtask

    // Every operation with hits, misses, duplicates and close-up on delete
    task automatic test_basic_ops();
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_INSERT, 32'sh5A5A_A5A5);
        send_item(OP_INSERT, VAL_MAX);          // duplicate
        send_item(OP_SEARCH, -32'sd1);
        send_item(OP_SEARCH, 32'sd12345);
        send_item(OP_SPARE, 32'sd0);
        send_item(OP_SPARE, 32'sd7);
        send_item(OP_DELETE, 32'sd0);           // middle entry, tail moves up
        send_item(OP_SEARCH, -32'sd1);
        send_item(OP_DELETE, 32'sd99);
        send_item(OP_DELETE, VAL_MIN);          // head
        send_item(OP_DELETE, 32'sh5A5A_A5A5);   // tail
        send_item(OP_SEARCH, VAL_MAX);
        send_item(OP_DELETE, VAL_MAX);
        send_item(OP_DELETE, -32'sd1);          // set now empty
        send_item(OP_SEARCH, -32'sd1);
        send_item(OP_DELETE, -32'sd1);
    endtask

    // Fill the set, then hit the full and duplicate-at-full cases
    task automatic test_fill_to_capacity();
        logic signed [VAL_W-1:0] v;
        while (shadow_set.size() < SET_CAPACITY) send_item(OP_INSERT, $urandom);
        do v = $urandom; while (v inside {shadow_set});
        send_item(OP_INSERT, v);                          // full
        send_item(OP_INSERT, shadow_set[SET_CAPACITY-1]); // duplicate wins over full
        send_item(OP_SEARCH, shadow_set[SET_CAPACITY-1]);
        send_item(OP_DELETE, shadow_set[0]);
        send_item(OP_SEARCH, shadow_set[shadow_set.size()-1]);
        send_item(OP_INSERT, v);
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_held_receiver();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                @(posedge i_clk);
                rsp_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rsp_hold = 1'b0;
            end
            begin
                repeat (40)
                    send_item($urandom_range(1) ? OP_INSERT : OP_SEARCH, pick_value());
            end
        join
    endtask

    // Random mix; the insert bias drifts so the set swings between empty and full
    task automatic test_random_mix(input int n_items, input int s_idle, input int r_idle);
        int ins_weight;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        ins_weight    = 50;
        for (int n = 0; n < n_items; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(3))
                    0: ins_weight = 15;
                    1: ins_weight = 35;
                    2: ins_weight = 55;
                    default: ins_weight = 75;
                endcase
            end
            send_item(pick_op(ins_weight), pick_value());
        end
    endtask

    // Main sequence
    initial begin
        req_if.valid     = 1'b0;
        req_if.operation = OP_SEARCH;
        req_if.value     = '0;
        rsp_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 70;
        test_empty_requests();
        test_basic_ops();
        test_fill_to_capacity();
        test_random_mix(PHASE_ITEMS, 38, 70);
        test_random_mix(PHASE_ITEMS, 70, 38);
        test_held_receiver();
        test_random_mix(PHASE_ITEMS, 0, 0);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        recv_idle_pct = 0;
        for (int w = 0; w < DRAIN_LIMIT && expected_replies.size() != 0; w++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_replies.size() != 0)
            report_mismatch("replies never arrived", expected_replies.size(), 0);
        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ouvs_pkg.sv
rtl/core/ouvs_req_if.sv
rtl/core/ouvs_rsp_if.sv
rtl/core/ouvs_cell.sv
rtl/core/ordered_unique_value_set_unit.sv
bench/tb_top.sv
